@@ design/activation_abs_histogram_unit_assert.svh @@
// Assertion macros for the activation histogram unit.
`ifndef ACTIVATION_ABS_HISTOGRAM_UNIT_ASSERT_SVH
`define ACTIVATION_ABS_HISTOGRAM_UNIT_ASSERT_SVH

// Checked only outside reset.
`define AHU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked in every cycle, reset included.
`define AHU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/ahu_pkg.sv @@
// ----------------------------------------------------------------------------
// ahu_pkg
// Shared types and constants of the activation histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ahu_pkg;

  localparam int KindW   = 2;
  localparam int SelW    = 11;
  localparam int MaxAbsW = 15;
  localparam int CountW  = 32;

  typedef enum logic [KindW-1:0] {
    KIND_MAX   = 2'd0,
    KIND_HIST  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [SelW-1:0]     sel;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/activation_abs_histogram_unit.sv @@
// Activation histogram unit: a max-pass sample, zero sample or out-of-range
// read is answered straight from the idle state; a read or a clamped histogram
// sample goes through the count memory read and write states, and a binned
// histogram sample first runs the one-bit-per-cycle bin divider before the
// read-modify-write on the single-port count memory. A clear writes every bin
// before its result; after reset a clearing pass runs with in_ready_o low. A
// two-entry queue lets requests enter while the back end works, and a result
// register holds each result until taken.
// ----------------------------------------------------------------------------
// activation_abs_histogram_unit
// Absolute-max and histogram statistics collector for int8 calibration.
// ----------------------------------------------------------------------------
`default_nettype none

module activation_abs_histogram_unit import ahu_pkg::*; #(
  parameter int N_BINS      = 2048,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [KindW-1:0]       kind_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SelW-1:0]        bin_select_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [MaxAbsW-1:0]     max_abs_o,
  output logic [CountW-1:0]      bin_count_o,
  output logic                   bin_saturated_o
);

  logic                   init_busy, ent_valid, ent_pop;
  cmd_t                   ent_cmd;
  logic [SAMPLE_BITS-2:0] ent_mag;

  ahu_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_i       (init_busy),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .sample_i     (sample_i),
    .bin_select_i (bin_select_i),
    .ent_valid_o  (ent_valid),
    .ent_pop_i    (ent_pop),
    .ent_cmd_o    (ent_cmd),
    .ent_mag_o    (ent_mag)
  );

  ahu_back #(.N_BINS(N_BINS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ent_valid_i     (ent_valid),
    .ent_pop_o       (ent_pop),
    .ent_cmd_i       (ent_cmd),
    .ent_mag_i       (ent_mag),
    .init_busy_o     (init_busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .max_abs_o       (max_abs_o),
    .bin_count_o     (bin_count_o),
    .bin_saturated_o (bin_saturated_o)
  );

endmodule

`default_nettype wire

@@ design/ahu_ram.sv @@
// ----------------------------------------------------------------------------
// ahu_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ahu_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/ahu_front.sv @@
// ----------------------------------------------------------------------------
// ahu_front
// Accepts requests, folds samples to saturated magnitudes and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module ahu_front import ahu_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   hold_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [KindW-1:0]       kind_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SelW-1:0]        bin_select_i,
  output logic                   ent_valid_o,
  input  logic                   ent_pop_i,
  output cmd_t                   ent_cmd_o,
  output logic [SAMPLE_BITS-2:0] ent_mag_o
);

  localparam int MagW = SAMPLE_BITS - 1;

  logic [MagW-1:0]        mag_q [2];
  cmd_t                   cmd_q [2];
  logic                   wr_ptr_q, rd_ptr_q;
  logic [1:0]             cnt_q;
  logic [SAMPLE_BITS-1:0] neg;
  logic [MagW-1:0]        mag;
  logic                   push;

  always_comb begin
    neg = (~sample_i) + SAMPLE_BITS'(1);
    if (sample_i == {1'b1, {MagW{1'b0}}}) begin
      mag = {MagW{1'b1}};
    end else if (sample_i[SAMPLE_BITS-1]) begin
      mag = neg[MagW-1:0];
    end else begin
      mag = sample_i[MagW-1:0];
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2) && !hold_i;
  assign push        = in_valid_i && in_ready_o;
  assign ent_valid_o = (cnt_q != 2'd0);
  assign ent_cmd_o   = cmd_q[rd_ptr_q];
  assign ent_mag_o   = mag_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mag_q[wr_ptr_q] <= mag;
      cmd_q[wr_ptr_q] <= '{kind: kind_e'(kind_i), sel: bin_select_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (ent_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, ent_pop_i};
    end
  end

endmodule

`default_nettype wire

@@ design/ahu_back.sv @@
// ----------------------------------------------------------------------------
// ahu_back
// Executes queued requests: running max, bin division, count update and read, clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ahu_back import ahu_pkg::*; #(
  parameter int N_BINS      = 2048,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   ent_valid_i,
  output logic                   ent_pop_o,
  input  cmd_t                   ent_cmd_i,
  input  logic [SAMPLE_BITS-2:0] ent_mag_i,
  output logic                   init_busy_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [MaxAbsW-1:0]     max_abs_o,
  output logic [CountW-1:0]      bin_count_o,
  output logic                   bin_saturated_o
);

  localparam int MagW  = SAMPLE_BITS - 1;
  localparam int IdxW  = $clog2(N_BINS);
  localparam int PW    = MagW + IdxW + 1;
  localparam int StepW = $clog2(IdxW);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD, S_WR, S_CLR} state_e;

  state_e              state_q, state_d;
  logic [MagW-1:0]     rmax_q, rmax_d, rem_q, rem_d;
  logic [IdxW-1:0]     idx_q, idx_d, low_q, low_d, clr_q, clr_d;
  logic [StepW-1:0]    step_q, step_d;
  logic                is_read_q, is_read_d, init_q, init_d;
  logic                out_valid_q, out_valid_d, out_sat_q, out_sat_d;
  logic [MaxAbsW-1:0]  out_max_q, out_max_d;
  logic [CountW-1:0]   out_cnt_q, out_cnt_d;
  logic                ram_we;
  logic [IdxW-1:0]     ram_addr;
  logic [CountW-1:0]   ram_wdata, ram_rdata;
  logic [PW-1:0]       prod;
  logic [MagW:0]       trial;
  logic                ge;
  logic [IdxW+SelW-1:0] sel_ext;
  logic [MagW+MaxAbsW-1:0] max_ext;

  ahu_ram #(.Width(CountW), .Depth(N_BINS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    rmax_d      = rmax_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    low_d       = low_q;
    clr_d       = clr_q;
    step_d      = step_q;
    is_read_d   = is_read_q;
    init_d      = init_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_max_d   = out_max_q;
    out_cnt_d   = out_cnt_q;
    out_sat_d   = out_sat_q;
    ent_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = idx_q;
    ram_wdata   = '0;
    prod        = PW'(ent_mag_i) * PW'(N_BINS);
    trial       = {rem_q, low_q[IdxW-1]};
    ge          = (trial >= {1'b0, rmax_q});
    sel_ext     = {{IdxW{1'b0}}, ent_cmd_i.sel};
    max_ext     = {{MaxAbsW{1'b0}}, rmax_q};

    unique case (state_q)
      S_IDLE: begin
        if (ent_valid_i && !out_valid_q) begin
          ent_pop_o = 1'b1;
          out_cnt_d = '0;
          out_sat_d = 1'b0;
          out_max_d = max_ext[MaxAbsW-1:0];
          unique case (ent_cmd_i.kind)
            KIND_MAX: begin
              out_valid_d = 1'b1;
              if (ent_mag_i > rmax_q) begin
                rmax_d  = ent_mag_i;
                max_ext = {{MaxAbsW{1'b0}}, ent_mag_i};
                out_max_d = max_ext[MaxAbsW-1:0];
              end
            end
            KIND_HIST: begin
              is_read_d = 1'b0;
              if (ent_mag_i == '0) begin
                out_valid_d = 1'b1;
              end else if (rmax_q == '0 || ent_mag_i >= rmax_q) begin
                idx_d   = IdxW'(N_BINS - 1);
                state_d = S_RD;
              end else begin
                rem_d   = prod[IdxW+MagW-1:IdxW];
                low_d   = prod[IdxW-1:0];
                idx_d   = '0;
                step_d  = '0;
                state_d = S_DIV;
              end
            end
            KIND_READ: begin
              if (32'(ent_cmd_i.sel) < 32'(N_BINS)) begin
                is_read_d = 1'b1;
                idx_d     = sel_ext[IdxW-1:0];
                state_d   = S_RD;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            KIND_CLEAR: begin
              rmax_d  = '0;
              clr_d   = '0;
              state_d = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        rem_d  = ge ? MagW'(trial - {1'b0, rmax_q}) : trial[MagW-1:0];
        low_d  = {low_q[IdxW-2:0], 1'b0};
        idx_d  = {idx_q[IdxW-2:0], ge};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(IdxW - 1)) state_d = S_RD;
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        out_valid_d = 1'b1;
        if (is_read_q) begin
          out_cnt_d = ram_rdata;
        end else if (ram_rdata == '1) begin
          out_sat_d = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata + CountW'(1);
        end
        state_d = S_IDLE;
      end
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        if (clr_q == IdxW'(N_BINS - 1)) begin
          if (!init_q) begin
            out_valid_d = 1'b1;
            out_max_d   = '0;
          end
          init_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + IdxW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      init_q      <= 1'b1;
      clr_q       <= '0;
      rmax_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      clr_q       <= clr_d;
      rmax_q      <= rmax_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    idx_q     <= idx_d;
    low_q     <= low_d;
    step_q    <= step_d;
    is_read_q <= is_read_d;
    out_max_q <= out_max_d;
    out_cnt_q <= out_cnt_d;
    out_sat_q <= out_sat_d;
  end

  assign init_busy_o     = init_q;
  assign out_valid_o     = out_valid_q;
  assign max_abs_o       = out_max_q;
  assign bin_count_o     = out_cnt_q;
  assign bin_saturated_o = out_sat_q;

endmodule

`default_nettype wire

@@ design/ahu_checker.sv @@
// ----------------------------------------------------------------------------
// ahu_checker
// Port-level checks of the activation histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "activation_abs_histogram_unit_assert.svh"

module ahu_checker import ahu_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [KindW-1:0]       kind_i,
  input logic [SAMPLE_BITS-1:0] sample_i,
  input logic [SelW-1:0]        bin_select_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [MaxAbsW-1:0]     max_abs_o,
  input logic [CountW-1:0]      bin_count_o,
  input logic                   bin_saturated_o
);

  logic [KindW+SAMPLE_BITS+SelW-1:0] in_bits;
  logic [MaxAbsW+CountW:0]           out_bits;

  assign in_bits  = {kind_i, sample_i, bin_select_i};
  assign out_bits = {max_abs_o, bin_count_o, bin_saturated_o};

  `AHU_ASSERT(a_in_hold, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_bits), "request changed")
  `AHU_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_bits), "result dropped")
  `AHU_ASSERT(a_sat_no_count, out_valid_o && bin_saturated_o |-> bin_count_o == '0, "sat with count")
  `AHU_ASSERT_ALWAYS(a_rst_no_out, !rst_ni |=> !out_valid_o, "result right after reset")
  `AHU_ASSERT_ALWAYS(a_rst_clearing, !rst_ni |=> !in_ready_o, "request taken during clearing")

endmodule

bind activation_abs_histogram_unit ahu_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ahu_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives max-pass, histogram, read and clear requests into the activation
// histogram unit under random idling and stalls, predicts every result from
// its own copy of the running max and bin counts, and checks each result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ahu_pkg::*;

  localparam int NBins     = 2048;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [MaxAbsW-1:0] max_abs;
    logic [CountW-1:0]  count;
    logic               sat;
  } stat_t;

  class hist_scoreboard;
    logic [MaxAbsW-1:0] run_max;
    logic [CountW-1:0]  counts [NBins];
    stat_t              pending [$];
    int                 errors;
    int                 checked;
    int                 last_bin;

    function new();
      run_max  = '0;
      errors   = 0;
      checked  = 0;
      last_bin = NBins - 1;
      foreach (counts[i]) counts[i] = '0;
    endfunction

    function automatic int magnitude(logic [15:0] s);
      if (s == 16'h8000) return 32767;
      return s[15] ? int'(-$signed(s)) : int'(s);
    endfunction

    function automatic int bin_index(int mag);
      longint q;
      if (run_max == 0) return NBins - 1;
      q = (longint'(mag) * NBins) / run_max;
      return (q > NBins - 1) ? NBins - 1 : int'(q);
    endfunction

    function void note_request(kind_e k, logic [15:0] s, logic [SelW-1:0] sel);
      stat_t e;
      int    mag;
      int    b;
      e   = '0;
      mag = magnitude(s);
      case (k)
        KIND_MAX: if (mag > run_max) run_max = mag[MaxAbsW-1:0];
        KIND_HIST: if (mag != 0) begin
          b = bin_index(mag);
          last_bin = b;
          if (counts[b] == '1) e.sat = 1'b1;
          else counts[b] = counts[b] + 1;
        end
        KIND_READ: e.count = counts[sel];
        default: begin
          run_max = '0;
          foreach (counts[i]) counts[i] = '0;
        end
      endcase
      e.max_abs = run_max;
      pending.insert(pending.size(), e);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [MaxAbsW-1:0] m, logic [CountW-1:0] c, logic s);
      stat_t e;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = pending.pop_front();
      checked++;
      if (m !== e.max_abs) report($sformatf("max_abs %0d, want %0d", m, e.max_abs));
      if (c !== e.count) report($sformatf("bin_count %0d, want %0d", c, e.count));
      if (s !== e.sat) report($sformatf("bin_saturated %0b, want %0b", s, e.sat));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [KindW-1:0]     kind_i;
  logic [15:0]          sample_i;
  logic [SelW-1:0]      bin_select_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [MaxAbsW-1:0]   max_abs_o;
  logic [CountW-1:0]    bin_count_o;
  logic                 bin_saturated_o;

  hist_scoreboard sb;
  int gap_pct;
  int stall_pct;
  int hold_cycles;
  int cycles;
  int sent;

  activation_abs_histogram_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .sample_i, .bin_select_i,
    .out_valid_o, .out_ready_i, .max_abs_o, .bin_count_o, .bin_saturated_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(max_abs_o, bin_count_o, bin_saturated_o);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** activation_abs_histogram_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_request(kind_e k, logic [15:0] s, logic [SelW-1:0] sel);
    while ($urandom_range(99) < gap_pct) @(negedge clk_i);
    in_valid_i   = 1'b1;
    kind_i       = k;
    sample_i     = s;
    bin_select_i = sel;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(k, s, sel);
    sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    int          bits;
    logic [15:0] v;
    if ($urandom_range(49) == 0) return 16'h8000;
    bits = $urandom_range(15, 1);
    v = 16'($urandom & ((32'd1 << bits) - 32'd1));
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic random_requests(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(199);
      if (r < 3) send_request(KIND_CLEAR, 16'($urandom), SelW'($urandom));
      else if (r < 50) send_request(KIND_MAX, rand_sample(), SelW'($urandom));
      else if (r < 150) send_request(KIND_HIST, rand_sample(), SelW'($urandom));
      else if (r < 165) send_request(KIND_READ, 16'($urandom), SelW'($urandom));
      else send_request(KIND_READ, 16'($urandom), sb.last_bin[SelW-1:0]);
    end
  endtask

  initial begin
    sb           = new();
    cycles       = 0;
    sent         = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    hold_cycles  = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_MAX;
    sample_i     = '0;
    bin_select_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty max, zero sample, extremes, clamps, reads, clear
    send_request(KIND_HIST, 16'd5, 11'd0);
    send_request(KIND_READ, 16'd0, 11'd2047);
    send_request(KIND_HIST, 16'd0, 11'd0);
    send_request(KIND_MAX, 16'h8000, 11'd0);
    send_request(KIND_MAX, 16'h7FFF, 11'd0);
    send_request(KIND_MAX, 16'hFFFF, 11'd0);
    send_request(KIND_HIST, 16'h8000, 11'd0);
    send_request(KIND_HIST, 16'h7FFF, 11'd0);
    send_request(KIND_HIST, 16'h0001, 11'd0);
    send_request(KIND_HIST, 16'hFFF0, 11'd0);
    send_request(KIND_READ, 16'd0, 11'd2047);
    send_request(KIND_READ, 16'd0, 11'd0);
    send_request(KIND_CLEAR, 16'd0, 11'd0);
    send_request(KIND_READ, 16'd0, 11'd2047);
    send_request(KIND_MAX, 16'd100, 11'd0);
    send_request(KIND_HIST, 16'hFF9C, 11'd0);
    send_request(KIND_HIST, 16'd50, 11'd0);
    send_request(KIND_HIST, 16'd400, 11'd0);
    send_request(KIND_READ, 16'd0, 11'd1024);
    send_request(KIND_READ, 16'd0, 11'd2047);

    random_requests(120);
    drain();
    gap_pct = 80;
    random_requests(120);
    gap_pct = 0;
    stall_pct = 80;
    hold_cycles = 400;
    random_requests(150);
    drain();
    repeat (30) @(negedge clk_i);
    stall_pct = 22;
    gap_pct = 22;
    random_requests(130);
    gap_pct = 0;
    stall_pct = 0;
    random_requests(100);

    drain();
    repeat (30) @(negedge clk_i);
    $display("Sent %0d requests, checked %0d results, %0d mismatches.",
             sent, sb.checked, sb.errors);
    $display("Covered max and histogram passes, reads, clears, stalls and back-pressure.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** activation_abs_histogram_unit: PASSED **");
    end else begin
      $display("** activation_abs_histogram_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+design
design/ahu_pkg.sv
design/ahu_ram.sv
design/ahu_front.sv
design/ahu_back.sv
design/activation_abs_histogram_unit.sv
design/ahu_checker.sv
bench/testbench.sv
